FILE: src/ctpl_pkg.sv
// Shared types and constants for the compressed tile payload layout unit.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ctpl_pkg;

	localparam int unsigned SUBBLOCKS   = 16;
	localparam int unsigned SIZE_W      = 6;
	localparam int unsigned PAYLOAD_W   = 13;
	localparam int unsigned OFFSET_W    = 32;
	localparam int unsigned GEN_W       = 4;
	localparam int unsigned UCB_W       = 9;
	localparam int unsigned CFG_DATA_W  = 9;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [GEN_W-1:0]     SOLID_MIN_GEN = 4'd7;
	localparam logic [GEN_W-1:0]     GEN_RESET     = 4'd7;
	localparam logic [UCB_W-1:0]     UCB_RESET     = 9'd64;
	localparam logic [PAYLOAD_W-1:0] ALIGN_MASK    = 13'd15;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_GPU_GENERATION = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNCOMP_BYTES   = 1'd1;

	typedef struct packed {
		logic [31:0] size_bits_low;
		logic [63:0] size_bits_high;
		logic        last_block;
	} in_word_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload_bytes;
		logic [OFFSET_W-1:0]  payload_offset;
		logic [OFFSET_W-1:0]  body_total;
		logic                 surface_done;
	} out_word_t;

	typedef struct packed {
		logic [GEN_W-1:0] gpu_generation;
		logic [UCB_W-1:0] uncompressed_subblock_bytes;
	} cfg_t;

endpackage
`default_nettype wire

FILE: src/ctpl_size_sum.sv
// Subblock size decode, adder tree, 16-byte rounding and solid zeroing;
// registers the payload size into stage 2. Depends on ctpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctpl_size_sum
	import ctpl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire in_word_t             word_s1,
	input  wire cfg_t                 cfg,
	output logic [PAYLOAD_W-1:0]      payload_s2,
	output logic                      last_s2
);

	logic [SUBBLOCKS*SIZE_W-1:0] bits;
	logic [UCB_W-1:0]            term  [SUBBLOCKS];
	logic [UCB_W:0]              lvl1  [SUBBLOCKS/2];
	logic [UCB_W+1:0]            lvl2  [SUBBLOCKS/4];
	logic [UCB_W+2:0]            lvl3  [SUBBLOCKS/8];
	logic [PAYLOAD_W-1:0]        sum;
	logic [PAYLOAD_W-1:0]        rounded;
	logic                        solid;

	assign bits = {word_s1.size_bits_high, word_s1.size_bits_low};

	always_comb begin
		for (int k = 0; k < SUBBLOCKS; k++) begin
			// stored size 1 marks an uncompressed subblock
			if (bits[k*SIZE_W +: SIZE_W] == 6'd1)
				term[k] = cfg.uncompressed_subblock_bytes;
			else
				term[k] = {{(UCB_W-SIZE_W){1'b0}}, bits[k*SIZE_W +: SIZE_W]};
		end
		for (int k = 0; k < SUBBLOCKS/2; k++)
			lvl1[k] = {1'b0, term[2*k]} + {1'b0, term[2*k+1]};
		for (int k = 0; k < SUBBLOCKS/4; k++)
			lvl2[k] = {1'b0, lvl1[2*k]} + {1'b0, lvl1[2*k+1]};
		for (int k = 0; k < SUBBLOCKS/8; k++)
			lvl3[k] = {1'b0, lvl2[2*k]} + {1'b0, lvl2[2*k+1]};
		sum = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};
	end

	// max sum 8176, so the rounding add cannot overflow 13 bits
	assign rounded = (sum + ALIGN_MASK) & ~ALIGN_MASK;
	assign solid   = (cfg.gpu_generation >= SOLID_MIN_GEN)
		&& (bits[SIZE_W-1:0] == 6'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			payload_s2 <= solid ? '0 : rounded;
			last_s2    <= word_s1.last_block;
		end
	end

endmodule
`default_nettype wire

FILE: src/ctpl_offset_acc.sv
// Running body offset and the output word register.
// Depends on ctpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctpl_offset_acc
	import ctpl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic [PAYLOAD_W-1:0] payload_s2,
	input  wire logic                 last_s2,
	output out_word_t                 out_word_q
);

	logic [OFFSET_W-1:0] running_offset_q;
	logic [OFFSET_W-1:0] total;

	assign total = running_offset_q
		+ {{(OFFSET_W-PAYLOAD_W){1'b0}}, payload_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_offset_q <= '0;
		end else if (en) begin
			running_offset_q <= last_s2 ? '0 : total;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word_q.payload_bytes  <= payload_s2;
			out_word_q.payload_offset <= running_offset_q;
			out_word_q.body_total     <= total;
			out_word_q.surface_done   <= last_s2;
		end
	end

endmodule
`default_nettype wire

FILE: src/compressed_tile_payload_layout_unit.sv
// Top level of the compressed tile payload layout unit: input register,
// configuration registers and pipeline control.
// Depends on ctpl_pkg, ctpl_size_sum and ctpl_offset_acc.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) takes one word per header:
//   bytes 4..15 of the header plus the last_block flag.
//   Output channel (out_valid / out_stall / out_word) gives one word per
//   header: aligned payload size, its body offset, the running total and
//   surface_done.
//   Three register stages: input register, payload size (adder tree),
//   output register with the running offset add. A result passes through
//   the input register, the payload size register and the output register.
//   Throughput is one word per cycle while out_stall is low; the offset
//   accumulate is a single 32-bit add per cycle and never holds back the stream.
//   When the receiver stalls, words pile up in the three stages; in_stall
//   rises only once all of them are full. Each stage moves on whenever the
//   stage after it is empty or moving.
//   Reset empties the pipeline, zeroes the running offset and loads
//   gpu_generation = 7, uncompressed_subblock_bytes = 64. Write the
//   registers (cfg_we / cfg_index / cfg_data) only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module compressed_tile_payload_layout_unit
	import ctpl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire in_word_t               in_word,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_word_t                   out_word,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t     cfg_q;
	in_word_t word_s1;
	logic     valid_s1;
	logic     valid_s2;
	logic     out_valid_q;
	logic     out_free;
	logic     s2_free;
	logic     s1_free;
	logic     s2_move;
	logic     s1_move;
	logic     in_take;
	logic [PAYLOAD_W-1:0] payload_s2;
	logic     last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gpu_generation              <= GEN_RESET;
			cfg_q.uncompressed_subblock_bytes <= UCB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GPU_GENERATION: cfg_q.gpu_generation <= cfg_data[GEN_W-1:0];
				CFG_UNCOMP_BYTES:   cfg_q.uncompressed_subblock_bytes <= cfg_data[UCB_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s2_move  = valid_s2 && out_free;
	assign s1_move  = valid_s1 && s2_free;
	assign in_take  = in_valid && s1_free;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= in_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (out_free)
				out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			word_s1 <= in_word;
	end

	ctpl_size_sum u_size_sum (
		.clk        (clk),
		.en         (s1_move),
		.word_s1    (word_s1),
		.cfg        (cfg_q),
		.payload_s2 (payload_s2),
		.last_s2    (last_s2)
	);

	ctpl_offset_acc u_offset_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (s2_move),
		.payload_s2 (payload_s2),
		.last_s2    (last_s2),
		.out_word_q (out_word)
	);

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: src/ctpl_checker.sv
// Port-level checks for the compressed tile payload layout unit, bound to
// the top level. Depends on ctpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ctpl_checker
	import ctpl_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_word_t out_word
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.payload_bytes[3:0] == 4'd0)
		else $error("payload size not 16-byte aligned");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.body_total == out_word.payload_offset
			+ {{(OFFSET_W-PAYLOAD_W){1'b0}}, out_word.payload_bytes})
		else $error("body total does not match offset plus payload");

	// back-to-back words chain their offsets, restarting after surface end
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) ##1 out_valid |->
			out_word.payload_offset == ($past(out_word.surface_done)
				? '0 : $past(out_word.body_total)))
		else $error("payload offset does not follow previous word");

endmodule

bind compressed_tile_payload_layout_unit ctpl_checker u_ctpl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
`default_nettype wire

FILE: tb/sv/ctpl_checker.sv
// Checker for the compressed tile payload layout unit: watches both channels
// and the register port, predicts each result word and compares it.
// Depends on ctpl_pkg.
`timescale 1ns / 1ps
module ctpl_tb_checker
	import ctpl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  in_word_t               in_word,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  out_word_t              out_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     words_seen,
	output int                     results_checked
);

	logic [GEN_W-1:0]    gen_reg;
	logic [UCB_W-1:0]    ucb_reg;
	logic [OFFSET_W-1:0] body_offset;
	out_word_t           expected_words[$];
	out_word_t           exp_w;
	logic [95:0]         hdr;

	// aligned payload of one header; solid blocks take no body space
	function automatic logic [PAYLOAD_W-1:0] layout_payload(input logic [95:0] h,
			input logic [GEN_W-1:0] gen, input logic [UCB_W-1:0] ucb);
		logic [PAYLOAD_W-1:0] sum;
		logic [SIZE_W-1:0]    sz;
		int                   k;
		if (gen >= SOLID_MIN_GEN && h[SIZE_W-1:0] == '0)
			return '0;
		sum = '0;
		for (k = 0; k < SUBBLOCKS; k++) begin
			sz = h[SIZE_W*k +: SIZE_W];
			sum = sum + ((sz == 6'd1) ? PAYLOAD_W'(ucb) : PAYLOAD_W'(sz));
		end
		return (sum + ALIGN_MASK) & ~ALIGN_MASK;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_reg = GEN_RESET;
			ucb_reg = UCB_RESET;
			body_offset = '0;
			expected_words.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					$display("%0t: result word with nothing expected, expected none actual %h",
						$time, out_word);
				end else begin
					exp_w = expected_words.pop_front();
					results_checked++;
					check_field("payload_bytes", 32'(exp_w.payload_bytes), 32'(out_word.payload_bytes));
					check_field("payload_offset", exp_w.payload_offset, out_word.payload_offset);
					check_field("body_total", exp_w.body_total, out_word.body_total);
					check_field("surface_done", 32'(exp_w.surface_done), 32'(out_word.surface_done));
				end
			end
			if (in_valid && !in_stall) begin
				hdr = {in_word.size_bits_high, in_word.size_bits_low};
				exp_w.payload_bytes = layout_payload(hdr, gen_reg, ucb_reg);
				exp_w.payload_offset = body_offset;
				exp_w.body_total = body_offset + OFFSET_W'(exp_w.payload_bytes);
				exp_w.surface_done = in_word.last_block;
				expected_words.push_back(exp_w);
				body_offset = in_word.last_block ? '0 : exp_w.body_total;
				words_seen++;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_GPU_GENERATION)
					gen_reg = cfg_data[GEN_W-1:0];
				else if (cfg_index == CFG_UNCOMP_BYTES)
					ucb_reg = cfg_data[UCB_W-1:0];
			end
			pending = expected_words.size();
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
		words_seen = 0;
		results_checked = 0;
	end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the compressed tile payload layout unit: clock, reset,
// header stimulus, register writes and the verdict.
// Depends on ctpl_pkg, compressed_tile_payload_layout_unit and ctpl_tb_checker.
`timescale 1ns / 1ps
module tb;
	import ctpl_pkg::*;

	localparam int SEGMENTS   = 8;
	localparam int SEG_WORDS  = 180;
	localparam int BIG_WORDS  = 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_word_t               in_word = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_word_t              out_word;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_GPU_GENERATION;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int fail_count;
	int pending;
	int words_seen;
	int results_checked;
	int idle_pct = 0;
	int stall_pct = 0;
	int settings = 0;

	compressed_tile_payload_layout_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	ctpl_tb_checker i_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_word        (in_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_word       (out_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending),
		.words_seen     (words_seen),
		.results_checked(results_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// one header word; holds valid until the unit takes it
	task automatic send_hdr(input logic [95:0] h, input logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word.size_bits_low <= h[31:0];
		in_word.size_bits_high <= h[95:32];
		in_word.last_block <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// upper data bits of the generation write are junk the unit must drop
	task automatic set_config(input logic [GEN_W-1:0] gen, input logic [UCB_W-1:0] ucb);
		logic [CFG_DATA_W-GEN_W-1:0] junk;
		junk = (CFG_DATA_W-GEN_W)'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GPU_GENERATION;
		cfg_data <= {junk, gen};
		@(posedge clk);
		cfg_index <= CFG_UNCOMP_BYTES;
		cfg_data <= ucb;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// mix of raw bits and headers built from the interesting sizes
	function automatic logic [95:0] rand_hdr();
		logic [95:0] h;
		int          k;
		int          mode;
		mode = $urandom_range(0, 9);
		h = {$urandom, $urandom, $urandom};
		if (mode >= 4) begin
			for (k = 0; k < SUBBLOCKS; k++) begin
				case ($urandom_range(0, 3))
					0: h[SIZE_W*k +: SIZE_W] = 6'd0;
					1: h[SIZE_W*k +: SIZE_W] = 6'd1;
					2: h[SIZE_W*k +: SIZE_W] = 6'h3f;
					default: ;
				endcase
			end
		end
		if (mode >= 8)
			h[SIZE_W-1:0] = 6'd0;
		return h;
	endfunction

	initial begin
		logic [95:0]      h;
		logic [GEN_W-1:0] gen;
		logic [UCB_W-1:0] ucb;
		int               seg;
		int               n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at reset register values
		idle_pct = 25;
		stall_pct = 64;
		send_hdr('0, 1'b0);
		send_hdr({16{6'h3f}}, 1'b0);
		send_hdr({16{6'd1}}, 1'b0);
		h = {16{6'h3f}};
		h[5:0] = 6'd0;
		send_hdr(h, 1'b0);
		send_hdr(96'd1, 1'b0);
		send_hdr(96'd2, 1'b0);
		send_hdr({24{4'ha}}, 1'b0);
		send_hdr({24{4'h5}}, 1'b0);
		// subblock straddling the low/high field boundary
		h = '0;
		h[5:0] = 6'd3;
		h[35:30] = 6'h3f;
		send_hdr(h, 1'b0);
		h = '0;
		h[5:0] = 6'd2;
		h[95:90] = 6'h3f;
		send_hdr(h, 1'b0);
		send_hdr({16{6'h3f}}, 1'b1);
		send_hdr({16{6'h3f}}, 1'b0);
		wait_idle();
		set_config(4'd6, 9'd0);
		h = {16{6'd1}};
		h[5:0] = 6'd0;
		send_hdr(h, 1'b0);
		send_hdr({16{6'd1}}, 1'b0);
		h = {16{6'h3f}};
		h[5:0] = 6'd0;
		send_hdr(h, 1'b1);
		wait_idle();
		set_config(4'd15, 9'd511);
		send_hdr({16{6'd1}}, 1'b0);
		send_hdr(96'd0, 1'b0);
		wait_idle();
		set_config(4'd0, 9'd256);
		send_hdr(h, 1'b0);
		send_hdr(96'd0, 1'b1);
		wait_idle();

		// random segments, one register setting each
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin gen = 4'd7; ucb = 9'd64; end
				1: begin gen = 4'd0; ucb = 9'd0; end
				2: begin gen = 4'd15; ucb = 9'd511; end
				3: begin gen = 4'd6; ucb = 9'd1; end
				4: begin gen = 4'd7; ucb = 9'd256; end
				6: begin gen = 4'd8; ucb = 9'd2; end
				default: begin gen = GEN_W'($urandom); ucb = UCB_W'($urandom); end
			endcase
			if (seg < 3) begin
				idle_pct = 25;
				stall_pct = 64;
			end else if (seg < 6) begin
				idle_pct = 64;
				stall_pct = 25;
			end else begin
				idle_pct = 0;
				stall_pct = 0;
			end
			set_config(gen, ucb);
			for (n = 0; n < SEG_WORDS; n++)
				send_hdr(rand_hdr(), ($urandom_range(0, 15) == 0));
			wait_idle();
		end

		// largest payloads back to back
		set_config(4'd7, 9'd511);
		for (n = 0; n < BIG_WORDS; n++)
			send_hdr({16{6'd1}}, 1'b0);
		send_hdr({16{6'd1}}, 1'b1);
		send_hdr({16{6'h3f}}, 1'b0);
		wait_idle();
		repeat (8) @(posedge clk);

		$display("covered %0d header words, %0d results checked, %0d register settings",
			words_seen, results_checked, settings);
		$display("solid and sized blocks, surface ends, three idle mixes, largest payloads");
		if (fail_count == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout with %0d results outstanding", pending);
		$display("tb NOT OK");
		$finish;
	end

endmodule
